### sv/tlaf_pkg.sv
// Shared types and constants of the text line annotate filter.
package tlaf_pkg;

	// Default depth of the queue between classifier and serializer
	localparam int unsigned QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_END_MARKS       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TAB_MARKS       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CARET_CTRL      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BLANK_FOLD      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_EVERY_MARK      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONEMPTY = 3'd6;

	// Character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CTRL_LIMIT  = 8'd32;
	localparam logic [7:0] CTRL_OFFSET = 8'd64;

	// Line counter: six BCD digits
	localparam int unsigned BCD_DIGITS = 6;
	localparam logic [23:0] BCD_ONE = 24'h000001;
	localparam logic [23:0] BCD_MAX = 24'h999999;
	localparam logic [3:0]  BCD_NINE = 4'd9;

	// Serializer positions: 0..5 digits, 6 the tab, 7..10 body bytes
	localparam logic [3:0] POS_TAB  = 4'd6;
	localparam logic [3:0] POS_BODY = 4'd7;

	// One classified item as handed from front to back
	typedef struct packed {
		logic            num;      // emit the line number first
		logic [23:0]     bcd;      // line number to print
		logic [3:0][7:0] body;     // expansion bytes of the input byte
		logic [1:0]      blen_m1;  // body length minus one
		logic            drop;     // squeezed line: one zero beat, flagged
	} desc_t;

	// Effective rendering options
	typedef struct packed {
		logic end_marks;
		logic tab_marks;
		logic caret_ctrl;
		logic blank_fold;
		logic every_mark;
		logic number_all;
		logic number_nonempty;
	} cfg_t;

endpackage

### sv/text_line_annotate_filter_unit.sv
// Top level of the text line annotate filter: front classifier, queue, back serializer.
//
// Takes one text byte per beat and delivers its expansion (line number and
// tab, caret or M- notation, trailing dollar) as one output byte per beat.
// The input takes one byte per clock while the descriptor queue (QUEUE_DEPTH
// entries) has room; the back serializer sends one output byte per clock while
// pop keeps its output register free, so long expansions (1 to 11 output bytes
// per input byte) fill the queue and raise full. An item's first output byte
// passes the queue, the descriptor register and the output register. A squeezed
// empty line yields one beat with out_byte 0 and dropped set. Configuration is
// written through cfg_wr_en, cfg_index and cfg_data while the block is idle;
// indexes beyond the register list are ignored. Only the user enforces the idle rule.
module text_line_annotate_filter_unit #(
	parameter int unsigned QUEUE_DEPTH = tlaf_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tlaf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic                             cfg_data,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       in_byte,
	input  logic                             file_start,
	output logic                             empty,
	input  logic                             pop,
	output logic [7:0]                       out_byte,
	output logic                             last_of_run,
	output logic                             dropped
);

	tlaf_pkg::desc_t front_desc;
	tlaf_pkg::desc_t head_desc;
	logic            accept;
	logic            head_valid;
	logic            head_pop;

	// Take an offered beat whenever the queue has room
	assign accept = push && !full;

	tlaf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.in_byte    (in_byte),
		.file_start (file_start),
		.desc       (front_desc)
	);

	tlaf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_desc  (front_desc),
		.full     (full),
		.rd_en    (head_pop),
		.rd_valid (head_valid),
		.rd_desc  (head_desc)
	);

	tlaf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (head_valid),
		.q_desc      (head_desc),
		.q_pop       (head_pop),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.dropped     (dropped)
	);

endmodule

### sv/tlaf_front.sv
// Front end: configuration registers, line state and classification of each input byte.
module tlaf_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tlaf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic                             cfg_data,
	input  logic                             accept,
	input  logic [7:0]                       in_byte,
	input  logic                             file_start,
	output tlaf_pkg::desc_t                  desc
);

	tlaf_pkg::cfg_t cfg_q;
	logic           at_line_start_q;
	logic           prev_line_empty_q;
	logic [23:0]    line_count_q;

	logic        eff_v, eff_t, eff_e;
	logic        is_nl, is_tab;
	logic        als, ple;
	logic        drop, num;
	logic [7:0]  low7;

	// Advance a six digit BCD count, holding at its maximum
	function automatic logic [23:0] bcd_next(input logic [23:0] v);
		logic [23:0] r;
		logic        carry;
		r = v;
		carry = 1'b1;
		for (int i = 0; i < tlaf_pkg::BCD_DIGITS; i++) begin
			if (carry) begin
				if (r[4*i +: 4] < tlaf_pkg::BCD_NINE) begin
					r[4*i +: 4] = r[4*i +: 4] + 4'd1;
					carry = 1'b0;
				end else begin
					r[4*i +: 4] = 4'd0;
				end
			end
		end
		if (v == tlaf_pkg::BCD_MAX) begin
			r = v;
		end
		return r;
	endfunction

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tlaf_pkg::REG_END_MARKS:       cfg_q.end_marks       <= cfg_data;
				tlaf_pkg::REG_TAB_MARKS:       cfg_q.tab_marks       <= cfg_data;
				tlaf_pkg::REG_CARET_CTRL:      cfg_q.caret_ctrl      <= cfg_data;
				tlaf_pkg::REG_BLANK_FOLD:      cfg_q.blank_fold      <= cfg_data;
				tlaf_pkg::REG_EVERY_MARK:      cfg_q.every_mark      <= cfg_data;
				tlaf_pkg::REG_NUMBER_ALL:      cfg_q.number_all      <= cfg_data;
				tlaf_pkg::REG_NUMBER_NONEMPTY: cfg_q.number_nonempty <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classify the byte against the line state
	always_comb begin
		eff_v  = cfg_q.caret_ctrl | cfg_q.every_mark;
		eff_t  = cfg_q.tab_marks | cfg_q.every_mark;
		eff_e  = cfg_q.end_marks | cfg_q.every_mark;
		is_nl  = (in_byte == tlaf_pkg::CH_NL);
		is_tab = (in_byte == tlaf_pkg::CH_TAB);
		als    = file_start | at_line_start_q;
		ple    = ~file_start & prev_line_empty_q;
		drop   = is_nl & als & cfg_q.blank_fold & ple;
		num    = ~drop & als & (cfg_q.number_nonempty ? ~is_nl : cfg_q.number_all);
		low7   = {1'b0, in_byte[6:0]};

		desc         = '0;
		desc.num     = num;
		desc.bcd     = line_count_q;
		desc.drop    = drop;
		desc.body[0] = in_byte;
		if (drop) begin
			desc.body[0] = 8'd0;
		end else if (eff_v && in_byte < tlaf_pkg::CTRL_LIMIT && !is_tab && !is_nl) begin
			desc.body[0] = tlaf_pkg::CH_CARET;
			desc.body[1] = in_byte + tlaf_pkg::CTRL_OFFSET;
			desc.blen_m1 = 2'd1;
		end else if (eff_v && in_byte == tlaf_pkg::CH_DEL) begin
			desc.body[0] = tlaf_pkg::CH_CARET;
			desc.body[1] = tlaf_pkg::CH_QMARK;
			desc.blen_m1 = 2'd1;
		end else if (eff_v && in_byte[7]) begin
			desc.body[0] = tlaf_pkg::CH_M;
			desc.body[1] = tlaf_pkg::CH_DASH;
			if (low7 < tlaf_pkg::CTRL_LIMIT) begin
				desc.body[2] = tlaf_pkg::CH_CARET;
				desc.body[3] = low7 + tlaf_pkg::CTRL_OFFSET;
				desc.blen_m1 = 2'd3;
			end else if (low7 == tlaf_pkg::CH_DEL) begin
				desc.body[2] = tlaf_pkg::CH_CARET;
				desc.body[3] = tlaf_pkg::CH_QMARK;
				desc.blen_m1 = 2'd3;
			end else begin
				desc.body[2] = low7;
				desc.blen_m1 = 2'd2;
			end
		end else if (eff_t && is_tab) begin
			desc.body[0] = tlaf_pkg::CH_CARET;
			desc.body[1] = tlaf_pkg::CH_I;
			desc.blen_m1 = 2'd1;
		end else if (eff_e && is_nl) begin
			desc.body[1] = tlaf_pkg::CH_DOLLAR;
			desc.blen_m1 = 2'd1;
		end
	end

	// Update line state and count on each kept beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q   <= 1'b1;
			prev_line_empty_q <= 1'b0;
			line_count_q      <= tlaf_pkg::BCD_ONE;
		end else if (accept && !drop) begin
			if (num) begin
				line_count_q <= bcd_next(line_count_q);
			end
			if (is_nl) begin
				prev_line_empty_q <= als;
				at_line_start_q   <= 1'b1;
			end else begin
				// a file start clears the empty-line history even mid-line
				prev_line_empty_q <= ple;
				at_line_start_q   <= 1'b0;
			end
		end
	end

	// Every counter digit stays decimal
	genvar gd;
	for (gd = 0; gd < tlaf_pkg::BCD_DIGITS; gd++) begin : g_digit_chk
		a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
			line_count_q[4*gd +: 4] <= tlaf_pkg::BCD_NINE)
			else $error("line count digit out of range");
	end

	// A squeezed line never reaches a fresh file start
	a_drop_state: assert property (@(posedge clk) disable iff (!arst_n)
		drop |-> (at_line_start_q && prev_line_empty_q && !file_start))
		else $error("drop outside an empty-line run");

endmodule

### sv/tlaf_queue.sv
// Short descriptor queue between classifier and serializer.
module tlaf_queue #(
	parameter int unsigned DEPTH = tlaf_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  tlaf_pkg::desc_t wr_desc,
	output logic            full,
	input  logic            rd_en,
	output logic            rd_valid,
	output tlaf_pkg::desc_t rd_desc
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	tlaf_pkg::desc_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == DEPTH_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_desc  = entry_q[rd_ptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("write into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid)
		else $error("read from empty queue");

endmodule

### sv/tlaf_back.sv
// Back end: serializes each descriptor into output bytes behind an output register.
module tlaf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  tlaf_pkg::desc_t q_desc,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            dropped
);

	tlaf_pkg::desc_t cur_q;
	logic            cur_valid_q;
	logic [3:0]      pos_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;
	logic            out_drop_q;

	logic            cur_last, out_free, adv;
	logic [3:0]      body_off;
	logic [7:0]      sel_byte;
	logic [7:0]      digit_char [tlaf_pkg::BCD_DIGITS];
	logic            lead;
	logic [3:0]      nib;

	// Render the number, most significant digit first, blanking leading zeros
	always_comb begin
		lead = 1'b1;
		for (int k = 0; k < tlaf_pkg::BCD_DIGITS; k++) begin
			nib  = cur_q.bcd[4*(tlaf_pkg::BCD_DIGITS-1-k) +: 4];
			lead = lead & (nib == 4'd0);
			if (lead && k < tlaf_pkg::BCD_DIGITS - 1) begin
				digit_char[k] = tlaf_pkg::CH_SPACE;
			end else begin
				digit_char[k] = tlaf_pkg::CH_ZERO +
					{4'd0, (nib > tlaf_pkg::BCD_NINE) ? tlaf_pkg::BCD_NINE : nib};
			end
		end
	end

	// Pick the byte at the current position
	always_comb begin
		body_off = pos_q - tlaf_pkg::POS_BODY;
		if (pos_q < tlaf_pkg::POS_TAB) begin
			sel_byte = digit_char[pos_q[2:0]];
		end else if (pos_q == tlaf_pkg::POS_TAB) begin
			sel_byte = tlaf_pkg::CH_TAB;
		end else begin
			sel_byte = cur_q.body[body_off[1:0]];
		end
	end

	assign cur_last = (pos_q == tlaf_pkg::POS_BODY + {2'b00, cur_q.blen_m1});
	assign out_free = !out_valid_q || pop;
	assign adv      = cur_valid_q && out_free;
	assign q_pop    = q_valid && (!cur_valid_q || (adv && cur_last));

	// Load the next descriptor or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			pos_q       <= q_desc.num ? 4'd0 : tlaf_pkg::POS_BODY;
		end else if (adv && cur_last) begin
			cur_valid_q <= 1'b0;
		end else if (adv) begin
			pos_q <= pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
		end
	end

	// Hold a result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= sel_byte;
			out_last_q <= cur_last;
			out_drop_q <= cur_q.drop;
		end
	end

	assign empty       = !out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;
	assign dropped     = out_drop_q;

	a_pos_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (pos_q <= tlaf_pkg::POS_BODY + {2'b00, cur_q.blen_m1}))
		else $error("serializer position past end of run");

	a_drop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_drop_q) |-> out_last_q)
		else $error("dropped beat not last of its run");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> cur_valid_q)
		else $error("descriptor load lost");

endmodule

### bench/text_line_annotate_filter_unit_test.sv
// Self-checking testbench of the text line annotate filter: directed table, then random text.
module text_line_annotate_filter_unit_test;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned MAX_GAP       = 17;
	localparam int unsigned TAIL_CYCLES   = 16;
	localparam int unsigned PHASE_ITEMS   = 16;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam logic [tlaf_pkg::CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [7:0] NUL_BYTE = 8'h00;

	typedef enum logic {STEP_TEXT, STEP_CFG} step_kind_t;

	// One row of the directed table; n_typed > 0 means the run is typed in
	typedef struct packed {
		step_kind_t     kind;
		logic [7:0]     ch;
		logic           fs;
		tlaf_pkg::cfg_t opts;
		logic [2:0]     n_typed;
		logic [31:0]    typed;
		logic           typed_drop;
	} step_t;

	typedef struct packed {
		logic [7:0] ob;
		logic       last;
		logic       drop;
	} beat_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_wr_en = 1'b0;
	logic [tlaf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic                             cfg_data = 1'b0;
	logic                             push = 1'b0;
	logic                             full;
	logic [7:0]                       in_byte = '0;
	logic                             file_start = 1'b0;
	logic                             empty;
	logic                             pop = 1'b0;
	logic [7:0]                       out_byte;
	logic                             last_of_run;
	logic                             dropped;

	// Shadow of the line state and options
	tlaf_pkg::cfg_t opts_now = '0;
	logic           line_start = 1'b1;
	logic           last_line_empty = 1'b0;
	logic [23:0]    line_bcd = tlaf_pkg::BCD_ONE;

	logic [7:0] run_q [$];
	beat_t      beats_due [$];
	beat_t      want_beat;

	int errors = 0;
	int beats_seen = 0;
	int bytes_sent = 0;
	int squeezed = 0;
	int settings_used = 0;
	int cycles = 0;
	int out_stall = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;

	text_line_annotate_filter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.in_byte     (in_byte),
		.file_start  (file_start),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.dropped     (dropped)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Draw a wait per beat; now and then flip into or out of a stretch with no waits
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		return calm ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	// Advance a six-digit BCD count, holding at its top value
	function automatic logic [23:0] bcd_bump(input logic [23:0] v);
		logic [23:0] r;
		logic        done;
		r = v;
		done = 1'b0;
		if (v == tlaf_pkg::BCD_MAX)
			return v;
		for (int i = 0; i < tlaf_pkg::BCD_DIGITS; i++) begin
			if (!done) begin
				if (r[4*i +: 4] < tlaf_pkg::BCD_NINE) begin
					r[4*i +: 4] = r[4*i +: 4] + 4'd1;
					done = 1'b1;
				end else begin
					r[4*i +: 4] = 4'd0;
				end
			end
		end
		return r;
	endfunction

	// Expand one input byte into run_q and update the line state; returns the squeeze flag
	function automatic logic annotate(input logic [7:0] ch, input logic fs);
		logic       eff_v;
		logic       eff_t;
		logic       eff_e;
		logic       is_nl;
		logic       lead;
		logic [3:0] d;
		logic [7:0] low;
		eff_v = opts_now.caret_ctrl | opts_now.every_mark;
		eff_t = opts_now.tab_marks | opts_now.every_mark;
		eff_e = opts_now.end_marks | opts_now.every_mark;
		is_nl = (ch == tlaf_pkg::CH_NL);
		run_q.delete();
		if (fs) begin
			line_start = 1'b1;
			last_line_empty = 1'b0;
		end
		// Drop a repeated empty line; state stays as is
		if (is_nl && line_start && opts_now.blank_fold && last_line_empty) begin
			run_q.push_back(NUL_BYTE);
			return 1'b1;
		end
		// Line number: blank-padded to six columns, then a raw tab
		if (line_start && (opts_now.number_nonempty ? !is_nl : opts_now.number_all)) begin
			lead = 1'b1;
			for (int i = tlaf_pkg::BCD_DIGITS - 1; i >= 0; i--) begin
				d = line_bcd[4*i +: 4];
				if (lead && d == 4'd0 && i > 0) begin
					run_q.push_back(tlaf_pkg::CH_SPACE);
				end else begin
					lead = 1'b0;
					run_q.push_back(tlaf_pkg::CH_ZERO + {4'd0, d});
				end
			end
			run_q.push_back(tlaf_pkg::CH_TAB);
			line_bcd = bcd_bump(line_bcd);
		end
		// Render the byte itself
		if (eff_v && ch < tlaf_pkg::CTRL_LIMIT && ch != tlaf_pkg::CH_TAB && !is_nl) begin
			run_q.push_back(tlaf_pkg::CH_CARET);
			run_q.push_back(ch + tlaf_pkg::CTRL_OFFSET);
		end else if (eff_v && ch == tlaf_pkg::CH_DEL) begin
			run_q.push_back(tlaf_pkg::CH_CARET);
			run_q.push_back(tlaf_pkg::CH_QMARK);
		end else if (eff_v && ch[7]) begin
			low = {1'b0, ch[6:0]};
			run_q.push_back(tlaf_pkg::CH_M);
			run_q.push_back(tlaf_pkg::CH_DASH);
			if (low < tlaf_pkg::CTRL_LIMIT) begin
				run_q.push_back(tlaf_pkg::CH_CARET);
				run_q.push_back(low + tlaf_pkg::CTRL_OFFSET);
			end else if (low == tlaf_pkg::CH_DEL) begin
				run_q.push_back(tlaf_pkg::CH_CARET);
				run_q.push_back(tlaf_pkg::CH_QMARK);
			end else begin
				run_q.push_back(low);
			end
		end else if (eff_t && ch == tlaf_pkg::CH_TAB) begin
			run_q.push_back(tlaf_pkg::CH_CARET);
			run_q.push_back(tlaf_pkg::CH_I);
		end else begin
			run_q.push_back(ch);
			if (eff_e && is_nl)
				run_q.push_back(tlaf_pkg::CH_DOLLAR);
		end
		if (is_nl) begin
			last_line_empty = line_start;
			line_start = 1'b1;
		end else begin
			line_start = 1'b0;
		end
		return 1'b0;
	endfunction

	// Turn run_q into expected beats, last one flagged
	function automatic void queue_expected(input logic drop);
		foreach (run_q[k])
			beats_due.push_back('{ob: run_q[k], last: (k == run_q.size() - 1), drop: drop});
		if (drop)
			squeezed++;
	endfunction

	function automatic step_t text_step(input logic [7:0] ch, input logic fs,
			input logic [2:0] n, input logic [31:0] typed, input logic drop);
		return '{kind: STEP_TEXT, ch: ch, fs: fs, opts: '0, n_typed: n, typed: typed,
			typed_drop: drop};
	endfunction

	function automatic step_t opt_step(input tlaf_pkg::cfg_t c);
		return '{kind: STEP_CFG, ch: '0, fs: 1'b0, opts: c, n_typed: '0, typed: '0,
			typed_drop: 1'b0};
	endfunction

	// Offer one input beat after a random gap and hold it until taken
	task automatic send_text(input logic [7:0] ch, input logic fs);
		int gap;
		gap = draw_gap(in_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_byte <= ch;
		file_start <= fs;
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	// Stop sending and wait until every expected beat has come out
	task automatic settle();
		push <= 1'b0;
		while (beats_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic drive_reg(input logic [tlaf_pkg::CFG_INDEX_W-1:0] idx, input logic v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	// Write all registers while idle, the unused index too
	task automatic apply_opts(input tlaf_pkg::cfg_t c);
		settle();
		drive_reg(tlaf_pkg::REG_END_MARKS, c.end_marks);
		drive_reg(tlaf_pkg::REG_TAB_MARKS, c.tab_marks);
		drive_reg(tlaf_pkg::REG_CARET_CTRL, c.caret_ctrl);
		drive_reg(tlaf_pkg::REG_BLANK_FOLD, c.blank_fold);
		drive_reg(tlaf_pkg::REG_EVERY_MARK, c.every_mark);
		drive_reg(tlaf_pkg::REG_NUMBER_ALL, c.number_all);
		drive_reg(tlaf_pkg::REG_NUMBER_NONEMPTY, c.number_nonempty);
		drive_reg(REG_SPARE, 1'($urandom_range(0, 1)));
		cfg_wr_en <= 1'b0;
		opts_now = c;
		settings_used++;
	endtask

	// Take output beats with random stalls and check them against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			beats_seen++;
			if (beats_due.size() == 0) begin
				$error("unexpected output beat: out_byte %02h", out_byte);
				errors++;
			end else begin
				want_beat = beats_due.pop_front();
				if (out_byte !== want_beat.ob) begin
					$error("out_byte: expected %02h, got %02h", want_beat.ob, out_byte);
					errors++;
				end
				if (last_of_run !== want_beat.last) begin
					$error("last_of_run: expected %0b, got %0b", want_beat.last, last_of_run);
					errors++;
				end
				if (dropped !== want_beat.drop) begin
					$error("dropped: expected %0b, got %0b", want_beat.drop, dropped);
					errors++;
				end
			end
			out_stall = draw_gap(out_calm);
		end
		if (out_stall > 0) begin
			out_stall--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("text_line_annotate_filter_unit_test: errors");
			$finish;
		end
	end

	initial begin
		step_t          plan [$];
		step_t          s;
		tlaf_pkg::cfg_t c;
		logic           drop;
		logic           fs;
		logic [7:0]     ch;
		int             cat;
		int             burst;
		int             sent;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table: defaults, then caret notation with squeeze, then everything on, then numbering of all lines
		plan.push_back(opt_step('0));
		plan.push_back(text_step(8'h61, 1'b1, 3'd1, 32'h61, 1'b0));
		plan.push_back(text_step(8'h00, 1'b0, 3'd1, 32'h00, 1'b0));
		plan.push_back(text_step(8'hFF, 1'b0, 3'd1, 32'hFF, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_TAB, 1'b0, 3'd1,
			{24'd0, tlaf_pkg::CH_TAB}, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_NL, 1'b0, 3'd1, {24'd0, tlaf_pkg::CH_NL}, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_NL, 1'b0, 3'd1, {24'd0, tlaf_pkg::CH_NL}, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_NL, 1'b0, 3'd1, {24'd0, tlaf_pkg::CH_NL}, 1'b0));
		c = '{caret_ctrl: 1'b1, blank_fold: 1'b1, default: 1'b0};
		plan.push_back(opt_step(c));
		plan.push_back(text_step(8'h01, 1'b0, 3'd2, {tlaf_pkg::CH_CARET, 8'h41}, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_DEL, 1'b0, 3'd2,
			{tlaf_pkg::CH_CARET, tlaf_pkg::CH_QMARK}, 1'b0));
		plan.push_back(text_step(8'h80, 1'b0, 3'd4,
			{tlaf_pkg::CH_M, tlaf_pkg::CH_DASH, tlaf_pkg::CH_CARET, 8'h40}, 1'b0));
		plan.push_back(text_step(8'h89, 1'b0, 3'd4,
			{tlaf_pkg::CH_M, tlaf_pkg::CH_DASH, tlaf_pkg::CH_CARET, 8'h49}, 1'b0));
		plan.push_back(text_step(8'h8A, 1'b0, 3'd4,
			{tlaf_pkg::CH_M, tlaf_pkg::CH_DASH, tlaf_pkg::CH_CARET, 8'h4A}, 1'b0));
		plan.push_back(text_step(8'hFF, 1'b0, 3'd4,
			{tlaf_pkg::CH_M, tlaf_pkg::CH_DASH, tlaf_pkg::CH_CARET, tlaf_pkg::CH_QMARK}, 1'b0));
		plan.push_back(text_step(8'hC1, 1'b0, 3'd3,
			{8'd0, tlaf_pkg::CH_M, tlaf_pkg::CH_DASH, 8'h41}, 1'b0));
		plan.push_back(text_step(8'h1F, 1'b0, 3'd2, {tlaf_pkg::CH_CARET, 8'h5F}, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_TAB, 1'b0, 3'd1,
			{24'd0, tlaf_pkg::CH_TAB}, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_NL, 1'b0, 3'd1, {24'd0, tlaf_pkg::CH_NL}, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_NL, 1'b0, 3'd1, {24'd0, tlaf_pkg::CH_NL}, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_NL, 1'b0, 3'd1, {24'd0, NUL_BYTE}, 1'b1));
		plan.push_back(text_step(tlaf_pkg::CH_NL, 1'b1, 3'd1, {24'd0, tlaf_pkg::CH_NL}, 1'b0));
		plan.push_back(opt_step('1));
		plan.push_back(text_step(tlaf_pkg::CH_TAB, 1'b0, 3'd0, '0, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_NL, 1'b0, 3'd0, '0, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_NL, 1'b0, 3'd0, '0, 1'b0));
		plan.push_back(text_step(tlaf_pkg::CH_NL, 1'b0, 3'd1, {24'd0, NUL_BYTE}, 1'b1));
		c = '{number_all: 1'b1, default: 1'b0};
		plan.push_back(opt_step(c));
		plan.push_back(text_step(8'h41, 1'b1, 3'd0, '0, 1'b0));

		// Walk the table; typed rows override the predicted run but still advance state
		foreach (plan[i]) begin
			s = plan[i];
			if (s.kind == STEP_CFG) begin
				apply_opts(s.opts);
			end else begin
				send_text(s.ch, s.fs);
				drop = annotate(s.ch, s.fs);
				if (s.n_typed != 3'd0) begin
					run_q.delete();
					for (int k = int'(s.n_typed) - 1; k >= 0; k--)
						run_q.push_back(s.typed[8*k +: 8]);
					drop = s.typed_drop;
				end
				queue_expected(drop);
			end
		end

		// Random text under several option sets, extremes first
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				c = '1;
			else if (p == 1)
				c = '0;
			else
				c = tlaf_pkg::cfg_t'(7'($urandom));
			apply_opts(c);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				cat = $urandom_range(0, 99);
				burst = 1;
				if (cat < 45) begin
					ch = 8'($urandom_range(32, 126));
				end else if (cat < 65) begin
					ch = tlaf_pkg::CH_NL;
					// runs of empty lines exercise squeezing
					if ($urandom_range(0, 3) == 0)
						burst = $urandom_range(2, 4);
				end else if (cat < 70) begin
					ch = tlaf_pkg::CH_TAB;
				end else if (cat < 78) begin
					ch = 8'($urandom_range(0, 31));
				end else if (cat < 82) begin
					ch = tlaf_pkg::CH_DEL;
				end else if (cat < 95) begin
					ch = 8'($urandom_range(128, 255));
				end else begin
					ch = 8'($urandom_range(0, 255));
				end
				fs = ($urandom_range(0, 15) == 0);
				repeat (burst) begin
					send_text(ch, fs);
					queue_expected(annotate(ch, fs));
					fs = 1'b0;
					sent++;
				end
			end
		end

		// Drain, then give the pipeline time to show any stray beat
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d input bytes and %0d output beats under %0d option sets",
			bytes_sent, beats_seen, settings_used);
		$display("squeezed lines: %0d, next line number (BCD): %06h", squeezed, line_bcd);
		if (errors == 0)
			$display("text_line_annotate_filter_unit_test: clean");
		else
			$display("text_line_annotate_filter_unit_test: errors");
		$finish;
	end

endmodule
